>>> sv/dqts_pkg.sv
// ----------------------------------------------------------------------------
// dqts_pkg
// Shared types and constants of the delta queue task scheduler: field widths,
// item kinds, controller states and the controller/datapath command and
// status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package dqts_pkg;

	localparam int unsigned KIND_W  = 2;
	localparam int unsigned TASK_W  = 4;
	localparam int unsigned FIELD_W = 16;
	localparam int unsigned PEND_W  = 5;

	localparam logic [KIND_W-1:0] KIND_ADD      = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TICK     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_WALK,
		ST_SHIFT_RD,
		ST_SHIFT,
		ST_PLACE,
		ST_TICK,
		ST_DISP,
		ST_POP,
		ST_POP_END,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_CAPTURE,
		OP_START,
		OP_WALK,
		OP_SHIFT_START,
		OP_SHIFT,
		OP_PLACE,
		OP_TICK,
		OP_DISP,
		OP_POP,
		OP_POP_END
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   out_load;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              cnt_zero;
		logic              cnt_one;
		logic              full;
		logic              walk_before;
		logic              ptr_last;
		logic              shift_none;
		logic              shift_at_pos;
		logic              head_ready;
		logic              per_nz;
		logic              out_free;
	} sts_t;

endpackage

`default_nettype wire

>>> sv/dqts_item_if.sv
// ----------------------------------------------------------------------------
// dqts_item_if
// Input channel of the scheduler: one beat is an add, tick or dispatch item.
// ----------------------------------------------------------------------------
`default_nettype none

interface dqts_item_if
	import dqts_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [TASK_W-1:0]  task_id;
	logic [FIELD_W-1:0] start_delay;
	logic [FIELD_W-1:0] repeat_period;

	modport source (
		output valid, kind, task_id, start_delay, repeat_period,
		input  ready
	);

	modport sink (
		input  valid, kind, task_id, start_delay, repeat_period,
		output ready
	);
endinterface

`default_nettype wire

>>> sv/dqts_result_if.sv
// ----------------------------------------------------------------------------
// dqts_result_if
// Output channel of the scheduler: one beat per accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

interface dqts_result_if
	import dqts_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              run_valid;
	logic [TASK_W-1:0] run_task;
	logic              add_rejected;
	logic [PEND_W-1:0] pending_count;

	modport source (
		output valid, run_valid, run_task, add_rejected, pending_count,
		input  ready
	);

	modport sink (
		input  valid, run_valid, run_task, add_rejected, pending_count,
		output ready
	);
endinterface

`default_nettype wire

>>> sv/dqts_ctrl.sv
// ----------------------------------------------------------------------------
// dqts_ctrl
// Controller of the scheduler: sequences the list walk, entry shifts, head
// update and result hand-off, one datapath operation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dqts_ctrl
	import dqts_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.op       = OP_IDLE;
		cmd.out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				// head entry is read here for every kind
				cmd.op = OP_START;
				case (sts.kind)
					KIND_ADD: begin
						if (sts.full) begin
							state_d = ST_DONE;
						end else if (sts.cnt_zero) begin
							state_d = ST_PLACE;
						end else begin
							state_d = ST_WALK;
						end
					end
					KIND_TICK:     state_d = sts.cnt_zero ? ST_DONE : ST_TICK;
					KIND_DISPATCH: state_d = sts.cnt_zero ? ST_DONE : ST_DISP;
					default:       state_d = ST_DONE;
				endcase
			end
			ST_WALK: begin
				cmd.op = OP_WALK;
				if (sts.walk_before || sts.ptr_last) begin
					state_d = ST_SHIFT_RD;
				end
			end
			ST_SHIFT_RD: begin
				cmd.op  = OP_SHIFT_START;
				state_d = sts.shift_none ? ST_PLACE : ST_SHIFT;
			end
			ST_SHIFT: begin
				cmd.op = OP_SHIFT;
				if (sts.shift_at_pos) begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				cmd.op  = OP_PLACE;
				state_d = ST_DONE;
			end
			ST_TICK: begin
				cmd.op  = OP_TICK;
				state_d = ST_DONE;
			end
			ST_DISP: begin
				cmd.op = OP_DISP;
				if (!sts.head_ready) begin
					state_d = ST_DONE;
				end else if (sts.cnt_one) begin
					state_d = ST_POP_END;
				end else begin
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				cmd.op = OP_POP;
				if (sts.ptr_last) begin
					state_d = ST_POP_END;
				end
			end
			ST_POP_END: begin
				// periodic task goes back in through the normal insert path
				cmd.op = OP_POP_END;
				if (!sts.per_nz) begin
					state_d = ST_DONE;
				end else if (sts.cnt_one) begin
					state_d = ST_PLACE;
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

>>> sv/dqts_dp.sv
// ----------------------------------------------------------------------------
// dqts_dp
// Datapath of the scheduler: entry memory with one write and one registered
// read port, walk and shift pointers, the item being worked on and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dqts_dp
	import dqts_pkg::*;
#(
	parameter int unsigned MAX_TASKS  = 16,
	parameter int unsigned DELAY_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [KIND_W-1:0]  kind,
	input  logic [TASK_W-1:0]  task_id,
	input  logic [FIELD_W-1:0] start_delay,
	input  logic [FIELD_W-1:0] repeat_period,
	input  logic               out_ready,
	output logic               out_valid,
	output logic               run_valid,
	output logic [TASK_W-1:0]  run_task,
	output logic               add_rejected,
	output logic [PEND_W-1:0]  pending_count
);

	localparam int unsigned IDX_W     = $clog2(MAX_TASKS);
	localparam int unsigned CNT_W     = $clog2(MAX_TASKS + 1);
	localparam int unsigned ENTRY_W   = TASK_W + 2 * DELAY_BITS + 1;
	localparam int unsigned PER_LSB   = 1;
	localparam int unsigned DELTA_LSB = DELAY_BITS + 1;
	localparam int unsigned TASK_LSB  = 2 * DELAY_BITS + 1;

	logic [ENTRY_W-1:0] mem_q [MAX_TASKS];
	logic [ENTRY_W-1:0] rd_q;

	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      ptr_q;
	logic [CNT_W-1:0]      pos_q;
	logic [KIND_W-1:0]     kind_q;
	logic [TASK_W-1:0]     id_q;
	logic [DELAY_BITS-1:0] d_q;
	logic [DELAY_BITS-1:0] per_q;
	logic                  rdy_q;
	logic                  run_valid_q;
	logic [TASK_W-1:0]     run_task_q;
	logic                  rejected_q;

	logic                  out_valid_q;
	logic                  out_run_valid_q;
	logic [TASK_W-1:0]     out_run_task_q;
	logic                  out_rejected_q;
	logic [PEND_W-1:0]     out_pending_q;

	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [ENTRY_W-1:0]    wr_data;

	logic [TASK_W-1:0]     e_task;
	logic [DELAY_BITS-1:0] e_delta;
	logic [DELAY_BITS-1:0] e_period;
	logic                  e_ready;
	logic [CNT_W-1:0]      count_m1;
	logic [CNT_W-1:0]      ptr_ext;
	logic [DELAY_BITS-1:0] d_rest;

	assign e_task   = rd_q[TASK_LSB +: TASK_W];
	assign e_delta  = rd_q[DELTA_LSB +: DELAY_BITS];
	assign e_period = rd_q[PER_LSB +: DELAY_BITS];
	assign e_ready  = rd_q[0];
	assign count_m1 = count_q - CNT_W'(1);
	assign ptr_ext  = CNT_W'(ptr_q);
	assign d_rest   = d_q - e_delta;

	// the head compares strictly, later entries let a tie go in front
	assign sts.kind         = kind_q;
	assign sts.cnt_zero     = (count_q == '0);
	assign sts.cnt_one      = (count_q == CNT_W'(1));
	assign sts.full         = (count_q == CNT_W'(MAX_TASKS));
	assign sts.walk_before  = (ptr_q == '0) ? (d_q < e_delta) : (d_q <= e_delta);
	assign sts.ptr_last     = (ptr_ext == count_m1);
	assign sts.shift_none   = (pos_q == count_q);
	assign sts.shift_at_pos = (ptr_ext == pos_q);
	assign sts.head_ready   = e_ready;
	assign sts.per_nz       = (per_q != '0);
	assign sts.out_free     = !out_valid_q || out_ready;

	// delta of the entry that ends up right behind the new one
	function automatic logic [DELAY_BITS-1:0] d_rest_fix(
		input logic [DELAY_BITS-1:0] delta,
		input logic [DELAY_BITS-1:0] d
	);
		d_rest_fix = delta - d;
	endfunction

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_q;
		case (cmd.op)
			OP_START: begin
				rd_en = 1'b1;
			end
			OP_WALK: begin
				if (!sts.walk_before && !sts.ptr_last) begin
					rd_en   = 1'b1;
					rd_addr = ptr_q + IDX_W'(1);
				end
			end
			OP_SHIFT_START: begin
				rd_en   = 1'b1;
				rd_addr = count_m1[IDX_W-1:0];
			end
			OP_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q + IDX_W'(1);
				if (sts.shift_at_pos) begin
					wr_data = {e_task, d_rest_fix(e_delta, d_q), e_period, e_ready};
				end else begin
					rd_en   = 1'b1;
					rd_addr = ptr_q - IDX_W'(1);
				end
			end
			OP_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = pos_q[IDX_W-1:0];
				wr_data = {id_q, d_q, per_q, rdy_q};
			end
			OP_TICK: begin
				wr_en = 1'b1;
				if (e_delta == '0) begin
					wr_data = {e_task, e_delta, e_period, 1'b1};
				end else begin
					wr_data = {e_task, e_delta - DELAY_BITS'(1), e_period, e_ready};
				end
			end
			OP_DISP: begin
				rd_en   = 1'b1;
				rd_addr = IDX_W'(1);
			end
			OP_POP: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q - IDX_W'(1);
				if (!sts.ptr_last) begin
					rd_en   = 1'b1;
					rd_addr = ptr_q + IDX_W'(1);
				end
			end
			OP_POP_END: begin
				rd_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				kind_q      <= kind;
				id_q        <= task_id;
				d_q         <= DELAY_BITS'(start_delay);
				per_q       <= DELAY_BITS'(repeat_period);
				rdy_q       <= (DELAY_BITS'(start_delay) == '0);
				run_valid_q <= 1'b0;
				run_task_q  <= '0;
				rejected_q  <= 1'b0;
			end
			OP_START: begin
				ptr_q      <= '0;
				pos_q      <= '0;
				rejected_q <= (kind_q == KIND_ADD) && sts.full;
			end
			OP_WALK: begin
				if (sts.walk_before) begin
					pos_q <= ptr_ext;
				end else begin
					d_q <= d_rest;
					if (sts.ptr_last) begin
						pos_q <= count_q;
					end else begin
						ptr_q <= ptr_q + IDX_W'(1);
					end
				end
			end
			OP_SHIFT_START: begin
				ptr_q <= count_m1[IDX_W-1:0];
			end
			OP_SHIFT: begin
				if (!sts.shift_at_pos) begin
					ptr_q <= ptr_q - IDX_W'(1);
				end
			end
			OP_DISP: begin
				ptr_q <= IDX_W'(1);
				if (e_ready) begin
					run_valid_q <= 1'b1;
					run_task_q  <= e_task;
					id_q        <= e_task;
					d_q         <= e_period;
					per_q       <= e_period;
					rdy_q       <= 1'b0;
				end
			end
			OP_POP: begin
				if (!sts.ptr_last) begin
					ptr_q <= ptr_q + IDX_W'(1);
				end
			end
			OP_POP_END: begin
				ptr_q <= '0;
				pos_q <= '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.op == OP_PLACE) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.op == OP_POP_END) begin
			count_q <= count_m1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_run_valid_q <= run_valid_q;
			out_run_task_q  <= run_task_q;
			out_rejected_q  <= rejected_q;
			out_pending_q   <= PEND_W'(count_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign run_valid     = out_run_valid_q;
	assign run_task      = out_run_task_q;
	assign add_rejected  = out_rejected_q;
	assign pending_count = out_pending_q;

endmodule

`default_nettype wire

>>> sv/delta_queue_task_scheduler_core.sv
// ----------------------------------------------------------------------------
// delta_queue_task_scheduler_core
// Timed task scheduler over a delta-ordered list held in one entry memory,
// split into a controller and a datapath.
//
//   channel  | dir | beat                                   | fields
//   ---------+-----+----------------------------------------+--------------------
//   item     | in  | add, tick or dispatch item             | kind, task_id,
//            |     |                                        | start_delay,
//            |     |                                        | repeat_period
//   result   | out | one beat per item                      | run_valid, run_task,
//            |     |                                        | add_rejected,
//            |     |                                        | pending_count
//
// one item at a time; the entry memory port paces the work, one entry a cycle
// tick or dispatch on an empty list, rejected add: result only; tick: head updated
// add: placed at once into an empty list, else a walk, a shift of any later entries, a place
// dispatch: a ready head is popped, moving every later entry once toward the head,
// then a periodic task is re-inserted as an add; a not-ready head is left in place
// a result waiting on a stalled sink does not block the next item's intake
// no clearing pass after reset: the list starts empty
// ----------------------------------------------------------------------------
`default_nettype none

module delta_queue_task_scheduler_core
	import dqts_pkg::*;
#(
	parameter int unsigned MAX_TASKS  = 16,
	parameter int unsigned DELAY_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	dqts_item_if.sink    item,
	dqts_result_if.source result
);

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	dqts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dqts_dp #(
		.MAX_TASKS  (MAX_TASKS),
		.DELAY_BITS (DELAY_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.kind          (item.kind),
		.task_id       (item.task_id),
		.start_delay   (item.start_delay),
		.repeat_period (item.repeat_period),
		.out_ready     (result.ready),
		.out_valid     (result.valid),
		.run_valid     (result.run_valid),
		.run_task      (result.run_task),
		.add_rejected  (result.add_rejected),
		.pending_count (result.pending_count)
	);

	assign item.ready = in_ready;

`ifndef ASSERT_OFF
	// an accepted item keeps the intake closed until its work is done
	assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("intake open while an item is in progress");

	// a full list never takes another entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_PLACE) |-> !sts.full)
		else $error("entry placed into a full list");

	// a dispatch beat and a rejected add never share a result
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.run_valid && result.add_rejected))
		else $error("result flags both a run and a rejected add");
`endif

endmodule

`default_nettype wire
